FILE: rtl/core/psev_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psev_pkg;

   // Fixed widths of the channel fields
   localparam int KIND_W   = 5;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_LITERAL  = 5'd0,
      KIND_VARIABLE = 5'd1,
      KIND_NOT      = 5'd2,
      KIND_OR       = 5'd3,
      KIND_AND      = 5'd4,
      KIND_MUL      = 5'd5,
      KIND_DIV      = 5'd6,
      KIND_MOD      = 5'd7,
      KIND_ADD      = 5'd8,
      KIND_SUB      = 5'd9,
      KIND_LT       = 5'd10,
      KIND_GT       = 5'd11,
      KIND_LE       = 5'd12,
      KIND_GE       = 5'd13,
      KIND_EQ       = 5'd14,
      KIND_NE       = 5'd15,
      KIND_COND     = 5'd16
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_DIVZERO   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WR_LITERAL,
      WR_COUNT,
      WR_ALU,
      WR_ITER
   } wr_sel_type;

   typedef enum logic [1:0] {
      ITER_MUL,
      ITER_DIV,
      ITER_MOD
   } iter_mode_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic          take;
      logic          op_shift;
      logic          wr_en;
      wr_sel_type    wr_sel;
      kind_type      alu_kind;
      logic          iter_start;
      iter_mode_type iter_mode;
      logic          rsp_load;
      status_type    rsp_status;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic divisor_zero;
      logic iter_done;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/psev_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface psev_req_if;
   import psev_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [WORD_W-1:0]   literal;
   logic [WORD_W-1:0]   count_value;
   logic                last_token;

   modport source (output valid, kind, literal, count_value, last_token, input ready);
   modport sink   (input valid, kind, literal, count_value, last_token, output ready);
endinterface

interface psev_rsp_if;
   import psev_pkg::*;

   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   value;
   logic [STATUS_W-1:0] status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/psev_iter.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared multi-cycle unit: shift-add multiply and restoring divide,
// one bit per cycle.
module psev_iter #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  psev_pkg::iter_mode_type    mode,
   input  logic [VALUE_WIDTH-1:0]     op_a,
   input  logic [VALUE_WIDTH-1:0]     op_b,
   output logic                       done,
   output logic [VALUE_WIDTH-1:0]     result
);
   import psev_pkg::*;

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   iter_mode_type          mode_ff, mode_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [VALUE_WIDTH-1:0] y_ff, y_in;

   logic [VALUE_WIDTH+1:0] trial;

   assign trial = {1'b0, acc_ff, x_ff[VALUE_WIDTH-1]} - {2'b00, y_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mode_in  = mode_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      if (start) begin
         busy_in  = 1'b1;
         mode_in  = mode;
         count_in = CW'(VALUE_WIDTH);
         acc_in   = '0;
         x_in     = op_a;
         y_in     = op_b;
      end else if (busy_ff) begin
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (mode_ff == ITER_MUL) begin
            // add shifted multiplicand when the multiplier bit is set
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = {x_ff[VALUE_WIDTH-2:0], 1'b0};
            y_in = {1'b0, y_ff[VALUE_WIDTH-1:1]};
         end else begin
            if (!trial[VALUE_WIDTH+1]) begin
               acc_in = trial[VALUE_WIDTH-1:0];
               x_in   = {x_ff[VALUE_WIDTH-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[VALUE_WIDTH-2:0], x_ff[VALUE_WIDTH-1]};
               x_in   = {x_ff[VALUE_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff  <= mode_in;
      count_ff <= count_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
   end

   assign done   = done_ff;
   assign result = (mode_ff == ITER_DIV) ? x_ff : acc_ff;

endmodule

`default_nettype wire

FILE: rtl/core/psev_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Datapath: operand stack memory, operand registers, ALU, iterative unit
// and the result register.
module psev_dp #(
   parameter int STACK_ENTRIES = 16,
   parameter int VALUE_WIDTH   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [psev_pkg::WORD_W-1:0]         req_literal,
   input  logic [psev_pkg::WORD_W-1:0]         req_count_value,
   input  psev_pkg::dp_cmd_type                cmd,
   input  logic [$clog2(STACK_ENTRIES)-1:0]    rd_addr,
   input  logic [$clog2(STACK_ENTRIES)-1:0]    wr_addr,
   output psev_pkg::dp_stat_type               stat,
   output logic [psev_pkg::WORD_W-1:0]         rsp_value,
   output logic [psev_pkg::STATUS_W-1:0]       rsp_status
);
   import psev_pkg::*;

   logic [VALUE_WIDTH-1:0] stack_ff [STACK_ENTRIES];
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic [VALUE_WIDTH-1:0] lit_ff;
   logic [VALUE_WIDTH-1:0] cnt_val_ff;
   logic [VALUE_WIDTH-1:0] op_c_ff;
   logic [VALUE_WIDTH-1:0] op_a_ff;
   logic [VALUE_WIDTH-1:0] op_b_ff;
   logic [WORD_W-1:0]      rsp_value_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;

   logic [VALUE_WIDTH-1:0] alu_result;
   logic [VALUE_WIDTH-1:0] iter_result;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [VALUE_WIDTH:0]   diff;
   logic                   a_lt_b;
   logic                   a_eq_b;
   logic                   iter_done;

   psev_iter #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_iter (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.iter_start),
      .mode   (cmd.iter_mode),
      .op_a   (op_a_ff),
      .op_b   (op_b_ff),
      .done   (iter_done),
      .result (iter_result)
   );

   assign diff   = {1'b0, op_a_ff} - {1'b0, op_b_ff};
   assign a_lt_b = diff[VALUE_WIDTH];
   assign a_eq_b = (op_a_ff == op_b_ff);

   always_comb begin
      case (cmd.alu_kind)
         KIND_NOT:  alu_result = VALUE_WIDTH'(op_b_ff == '0);
         KIND_OR:   alu_result = VALUE_WIDTH'((op_a_ff != '0) || (op_b_ff != '0));
         KIND_AND:  alu_result = VALUE_WIDTH'((op_a_ff != '0) && (op_b_ff != '0));
         KIND_ADD:  alu_result = op_a_ff + op_b_ff;
         KIND_SUB:  alu_result = diff[VALUE_WIDTH-1:0];
         KIND_LT:   alu_result = VALUE_WIDTH'(a_lt_b);
         KIND_GT:   alu_result = VALUE_WIDTH'(!a_lt_b && !a_eq_b);
         KIND_LE:   alu_result = VALUE_WIDTH'(a_lt_b || a_eq_b);
         KIND_GE:   alu_result = VALUE_WIDTH'(!a_lt_b);
         KIND_EQ:   alu_result = VALUE_WIDTH'(a_eq_b);
         KIND_NE:   alu_result = VALUE_WIDTH'(!a_eq_b);
         KIND_COND: alu_result = (op_c_ff != '0) ? op_a_ff : op_b_ff;
         default:   alu_result = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_LITERAL: wr_data = lit_ff;
         WR_COUNT:   wr_data = cnt_val_ff;
         WR_ALU:     wr_data = alu_result;
         WR_ITER:    wr_data = iter_result;
         default:    wr_data = '0;
      endcase
   end

   // Stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= stack_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         lit_ff     <= VALUE_WIDTH'(req_literal);
         cnt_val_ff <= VALUE_WIDTH'(req_count_value);
      end
      // shift operands in, top of stack lands in op_b
      if (cmd.op_shift) begin
         op_c_ff <= op_a_ff;
         op_a_ff <= op_b_ff;
         op_b_ff <= rdata_ff;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= (cmd.rsp_status == STATUS_OK) ? WORD_W'(rdata_ff) : '0;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign stat.divisor_zero = (op_b_ff == '0);
   assign stat.iter_done    = iter_done;
   assign rsp_value         = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

FILE: rtl/core/psev_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Controller: token decode, stack pointer, error latch and sequencing.
module psev_ctrl #(
   parameter int STACK_ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [psev_pkg::KIND_W-1:0]         req_kind,
   input  logic                                req_last,
   output logic                                req_ready,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   input  psev_pkg::dp_stat_type               stat,
   output psev_pkg::dp_cmd_type                cmd,
   output logic [$clog2(STACK_ENTRIES)-1:0]    rd_addr,
   output logic [$clog2(STACK_ENTRIES)-1:0]    wr_addr
);
   import psev_pkg::*;

   localparam int AW  = $clog2(STACK_ENTRIES);
   localparam int SPW = $clog2(STACK_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_SETTLE,
      ST_COMPUTE,
      ST_WAIT,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in;
   status_type err_ff, err_in;
   kind_type   kind_ff, kind_in;
   logic       last_ff, last_in;
   logic [1:0] need_ff, need_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       cap_ff, cap_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [SPW-1:0] rd_ptr;
   logic [SPW-1:0] sp_base;
   logic [1:0]     need;

   assign rd_ptr  = sp_ff - SPW'(cnt_ff);
   assign sp_base = sp_ff - SPW'(need_ff);

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      need_in      = need_ff;
      cnt_in       = cnt_ff;
      cap_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      need         = 2'd0;
      cmd          = '0;
      cmd.alu_kind = kind_ff;
      cmd.op_shift = cap_ff;
      rd_addr      = '0;
      wr_addr      = sp_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               kind_in  = kind_type'(req_kind);
               last_in  = req_last;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            if (err_ff == STATUS_OK) begin
               unique case (kind_ff) inside
                  KIND_LITERAL, KIND_VARIABLE: begin
                     if (sp_ff == SPW'(STACK_ENTRIES)) begin
                        err_in = STATUS_OVERFLOW;
                     end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = (kind_ff == KIND_LITERAL) ? WR_LITERAL : WR_COUNT;
                        sp_in      = sp_ff + SPW'(1);
                     end
                  end
                  KIND_NOT, KIND_OR, KIND_AND, KIND_MUL, KIND_DIV, KIND_MOD,
                  KIND_ADD, KIND_SUB, KIND_LT, KIND_GT, KIND_LE, KIND_GE,
                  KIND_EQ, KIND_NE, KIND_COND: begin
                     if (kind_ff == KIND_NOT) begin
                        need = 2'd1;
                     end else if (kind_ff == KIND_COND) begin
                        need = 2'd3;
                     end else begin
                        need = 2'd2;
                     end
                     if (sp_ff < SPW'(need)) begin
                        err_in = STATUS_MALFORMED;
                     end else begin
                        need_in  = need;
                        cnt_in   = need;
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                     err_in = STATUS_MALFORMED;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            // read deepest operand first, capture it in the following cycle
            rd_addr = rd_ptr[AW-1:0];
            cnt_in  = cnt_ff - 2'd1;
            cap_in  = 1'b1;
            if (cnt_ff == 2'd1) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_COMPUTE;
         end
         ST_COMPUTE: begin
            unique case (kind_ff) inside
               KIND_MUL: begin
                  cmd.iter_start = 1'b1;
                  cmd.iter_mode  = ITER_MUL;
                  state_in       = ST_WAIT;
               end
               KIND_DIV, KIND_MOD: begin
                  if (stat.divisor_zero) begin
                     err_in   = STATUS_DIVZERO;
                     state_in = ST_FINISH;
                  end else begin
                     cmd.iter_start = 1'b1;
                     cmd.iter_mode  = (kind_ff == KIND_DIV) ? ITER_DIV : ITER_MOD;
                     state_in       = ST_WAIT;
                  end
               end
               default: begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WR_ALU;
                  wr_addr    = sp_base[AW-1:0];
                  sp_in      = sp_base + SPW'(1);
                  state_in   = ST_FINISH;
               end
            endcase
         end
         ST_WAIT: begin
            if (stat.iter_done) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_ITER;
               wr_addr    = sp_base[AW-1:0];
               sp_in      = sp_base + SPW'(1);
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff) begin
               // fetch the bottom entry for the result
               rd_addr  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.rsp_load = 1'b1;
            if (err_ff != STATUS_OK) begin
               cmd.rsp_status = err_ff;
            end else if (sp_ff != SPW'(1)) begin
               cmd.rsp_status = STATUS_MALFORMED;
            end else begin
               cmd.rsp_status = STATUS_OK;
            end
            rsp_valid_in = 1'b1;
            sp_in        = '0;
            err_in       = STATUS_OK;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         err_ff       <= STATUS_OK;
         cap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      last_ff <= last_in;
      need_ff <= need_in;
      cnt_ff  <= cnt_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                   Notes
// req_chan  in   kind, literal, count_value, last_token   one token per request
// rsp_chan  out  value, status                            one per last_token request
//
// Sequence: a push or a rejected token passes through decode and finish before
// ready returns; not, logic, add/sub, compare and conditional also read the
// stack memory once per operand, settle and compute; mul, div and mod read their
// operands and then run the one-bit-per-cycle shift-add / restoring unit, which
// a zero divisor skips. A last token adds a state to load the bottom entry into the result register.
// Reset clears the stack pointer, the error latch and the result valid flag.
// The result register holds while rsp_chan stalls; only a last token waits on it.
module postfix_stack_evaluator_unit #(
   parameter int STACK_ENTRIES = 16,
   parameter int VALUE_WIDTH   = 32
) (
   input  logic       clock,
   input  logic       reset,
   psev_req_if.sink   req_chan,
   psev_rsp_if.source rsp_chan
);
   import psev_pkg::*;

   localparam int AW = $clog2(STACK_ENTRIES);

   dp_cmd_type    cmd;
   dp_stat_type   stat;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   // Controller: decode each request, track depth and the first error,
   // sequence operand reads, ALU or iterative work, and the result write.
   psev_ctrl #(
      .STACK_ENTRIES (STACK_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_last  (req_chan.last_token),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .stat      (stat),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   // Datapath: stack memory, operand registers, ALU, mul/div unit and the
   // result register that drives rsp_chan.
   psev_dp #(
      .STACK_ENTRIES (STACK_ENTRIES),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_literal     (req_chan.literal),
      .req_count_value (req_chan.count_value),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr),
      .stat            (stat),
      .rsp_value       (rsp_chan.value),
      .rsp_status      (rsp_chan.status)
   );

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import psev_pkg::*;

   localparam int STACK_ENTRIES = 16;
   localparam int VALUE_WIDTH   = 32;
   localparam int MIX_TOKENS    = 440;
   localparam int BURST_TOKENS  = 150;
   localparam int IDLE_PCT      = 18;
   localparam int STALL_CYCLES  = 300;
   localparam int DRAIN_CYCLES  = 2 * VALUE_WIDTH + 40;
   localparam int CYCLE_LIMIT   = 600000;

   // Kinds past the conditional are all rejected as malformed
   localparam logic [KIND_W-1:0] KIND_FIRST_INVALID = 5'd17;
   localparam logic [KIND_W-1:0] KIND_LAST_INVALID  = 5'd31;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] literal;
      logic [WORD_W-1:0] count_value;
      logic              last_token;
   } token_type;

   typedef struct {
      logic [WORD_W-1:0] value;
      status_type        status;
   } eval_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psev_req_if req_chan ();
   psev_rsp_if rsp_chan ();

   postfix_stack_evaluator_unit #(
      .STACK_ENTRIES (STACK_ENTRIES),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirror of the evaluator: operand stack, depth and latched error
   logic [WORD_W-1:0] operand_mirror [STACK_ENTRIES];
   int unsigned       mirror_depth = 0;
   status_type        latched_error = STATUS_OK;

   eval_result_type   awaited_results [$];
   token_type         expr_tokens [$];
   int unsigned       tokens_evaluated = 0;
   int unsigned       failures = 0;
   int unsigned       cycle_count = 0;
   bit                sender_gaps = 1'b1;
   bit                receiver_gaps = 1'b1;
   bit                stall_request = 1'b0;

   // Toggle the clock: 4 ns high, 4 ns low
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Apply one accepted request to the mirror; queue the result on a last token
   function automatic void evaluate_token(token_type tok);
      logic [WORD_W-1:0] lhs;
      logic [WORD_W-1:0] rhs;
      logic [WORD_W-1:0] outcome;
      eval_result_type   res;
      tokens_evaluated++;
      // Skip everything after the first error until the expression ends
      if (latched_error == STATUS_OK) begin
         case (tok.kind)
            KIND_LITERAL, KIND_VARIABLE: begin
               if (mirror_depth >= STACK_ENTRIES) begin
                  latched_error = STATUS_OVERFLOW;
               end else begin
                  operand_mirror[mirror_depth] =
                     (tok.kind == KIND_LITERAL) ? tok.literal : tok.count_value;
                  mirror_depth++;
               end
            end
            KIND_NOT: begin
               if (mirror_depth < 1) begin
                  latched_error = STATUS_MALFORMED;
               end else begin
                  operand_mirror[mirror_depth-1] =
                     WORD_W'(operand_mirror[mirror_depth-1] == '0);
               end
            end
            KIND_COND: begin
               // condition sits deepest, then the true and the false operand
               if (mirror_depth < 3) begin
                  latched_error = STATUS_MALFORMED;
               end else begin
                  mirror_depth -= 2;
                  operand_mirror[mirror_depth-1] = (operand_mirror[mirror_depth-1] != '0) ?
                     operand_mirror[mirror_depth] : operand_mirror[mirror_depth+1];
               end
            end
            default: begin
               if (tok.kind > KIND_COND || mirror_depth < 2) begin
                  latched_error = STATUS_MALFORMED;
               end else begin
                  lhs = operand_mirror[mirror_depth-2];
                  rhs = operand_mirror[mirror_depth-1];
                  if ((tok.kind == KIND_DIV || tok.kind == KIND_MOD) && rhs == '0) begin
                     latched_error = STATUS_DIVZERO;
                  end else begin
                     case (tok.kind)
                        KIND_OR:  outcome = WORD_W'((lhs != '0) || (rhs != '0));
                        KIND_AND: outcome = WORD_W'((lhs != '0) && (rhs != '0));
                        KIND_MUL: outcome = lhs * rhs;
                        KIND_DIV: outcome = lhs / rhs;
                        KIND_MOD: outcome = lhs % rhs;
                        KIND_ADD: outcome = lhs + rhs;
                        KIND_SUB: outcome = lhs - rhs;
                        KIND_LT:  outcome = WORD_W'(lhs < rhs);
                        KIND_GT:  outcome = WORD_W'(lhs > rhs);
                        KIND_LE:  outcome = WORD_W'(lhs <= rhs);
                        KIND_GE:  outcome = WORD_W'(lhs >= rhs);
                        KIND_EQ:  outcome = WORD_W'(lhs == rhs);
                        default:  outcome = WORD_W'(lhs != rhs);
                     endcase
                     mirror_depth--;
                     operand_mirror[mirror_depth-1] = outcome;
                  end
               end
            end
         endcase
      end
      // Close the expression: report, then empty the stack and clear the error
      if (tok.last_token) begin
         res.status = latched_error;
         if (res.status == STATUS_OK && mirror_depth != 1)
            res.status = STATUS_MALFORMED;
         res.value = (res.status == STATUS_OK) ? operand_mirror[0] : '0;
         awaited_results.push_back(res);
         mirror_depth  = 0;
         latched_error = STATUS_OK;
      end
   endfunction

   // Compare each accepted result with the oldest one awaited
   always @(posedge clock) begin
      eval_result_type oldest;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result: value %h status %0d", rsp_chan.value, rsp_chan.status);
            failures++;
         end else begin
            oldest = awaited_results.pop_front();
            if (rsp_chan.value !== oldest.value) begin
               $error("value: expected %h, actual %h", oldest.value, rsp_chan.value);
               failures++;
            end
            if (rsp_chan.status !== oldest.status) begin
               $error("status: expected %0d, actual %0d", oldest.status, rsp_chan.status);
               failures++;
            end
         end
      end
   end

   // Drive ready at the falling edge; hold it low for a long stretch on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request  = 1'b0;
            rsp_chan.ready = 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
         end
         rsp_chan.ready = !(receiver_gaps && $urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic token_type make_token(logic [KIND_W-1:0] kind,
                                            logic [WORD_W-1:0] literal,
                                            logic [WORD_W-1:0] count_value,
                                            logic last_token);
      token_type tok;
      tok.kind        = kind;
      tok.literal     = literal;
      tok.count_value = count_value;
      tok.last_token  = last_token;
      return tok;
   endfunction

   function automatic token_type random_token();
      return make_token(KIND_W'($urandom_range(KIND_LAST_INVALID)), $urandom(), $urandom(),
                        $urandom_range(4) == 0);
   endfunction

   // Favor small operands so that equal compares and zero divisors show up often
   function automatic logic [WORD_W-1:0] pick_operand();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return $urandom_range(7);
         6:                return '1;
         7:                return {1'b1, {(WORD_W-1){1'b0}}};
         default:          return $urandom();
      endcase
   endfunction

   // Build a well-formed expression: a body of body_len tokens, then reduce to one
   function automatic void build_expression(int body_len, int push_pct);
      token_type tok;
      int        depth;
      int        i;
      int        roll;
      bit        closing;
      expr_tokens.delete();
      depth = 0;
      for (i = 0; i < body_len || depth > 1; i++) begin
         tok = random_token();
         tok.last_token = 1'b0;
         closing = (i >= body_len);
         roll = $urandom_range(99);
         if (depth >= 3 && roll < 8) begin
            tok.kind = KIND_COND;
            depth -= 2;
         end else if (depth >= 2 && (closing || roll >= push_pct ||
                      (depth >= STACK_ENTRIES && $urandom_range(99) >= 4))) begin
            tok.kind = KIND_W'($urandom_range(KIND_NE, KIND_OR));
            depth--;
         end else if (depth >= 1 && !closing && roll < 14) begin
            tok.kind = KIND_NOT;
         end else begin
            // a push on a full stack is left in now and then to hit overflow
            if ($urandom_range(1)) begin
               tok.kind        = KIND_VARIABLE;
               tok.count_value = pick_operand();
            end else begin
               tok.kind    = KIND_LITERAL;
               tok.literal = pick_operand();
            end
            if (depth < STACK_ENTRIES)
               depth++;
         end
         expr_tokens.push_back(tok);
      end
      expr_tokens[expr_tokens.size()-1].last_token = 1'b1;
   endfunction

   // Offer one request at the falling edge, with random gaps, and wait for acceptance
   task automatic send_token(token_type tok);
      @(negedge clock);
      while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.kind        = tok.kind;
      req_chan.literal     = tok.literal;
      req_chan.count_value = tok.count_value;
      req_chan.last_token  = tok.last_token;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      evaluate_token(tok);
   endtask

   task automatic send_expression();
      foreach (expr_tokens[i])
         send_token(expr_tokens[i]);
   endtask

   // Drop valid and hold off until every awaited result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // All-ones and zero operands, with add wrapping to zero
   task automatic test_operand_extremes();
      send_token(make_token(KIND_LITERAL, '1, '0, 1'b1));
      send_token(make_token(KIND_VARIABLE, '0, '1, 1'b0));
      send_token(make_token(KIND_LITERAL, 32'd1, '1, 1'b0));
      send_token(make_token(KIND_ADD, '0, '0, 1'b1));
      send_token(make_token(KIND_VARIABLE, '1, '0, 1'b0));
      send_token(make_token(KIND_NOT, '1, '1, 1'b1));
   endtask

   task automatic test_error_cases();
      // operator on an empty stack
      send_token(make_token(KIND_ADD, '0, '0, 1'b1));
      // both ends of the invalid kind range
      send_token(make_token(KIND_FIRST_INVALID, '1, '1, 1'b1));
      send_token(make_token(KIND_LAST_INVALID, '1, '1, 1'b1));
      // modulo by zero, then a push that must be ignored
      send_token(make_token(KIND_LITERAL, 32'd5, '0, 1'b0));
      send_token(make_token(KIND_LITERAL, '0, '0, 1'b0));
      send_token(make_token(KIND_MOD, '0, '0, 1'b0));
      send_token(make_token(KIND_LITERAL, 32'd4, '0, 1'b1));
      // two values left at the end
      send_token(make_token(KIND_LITERAL, 32'd1, '0, 1'b0));
      send_token(make_token(KIND_LITERAL, 32'd2, '0, 1'b1));
      // conditional with a single operand
      send_token(make_token(KIND_LITERAL, 32'd7, '0, 1'b0));
      send_token(make_token(KIND_COND, '0, '0, 1'b0));
      send_token(make_token(KIND_LITERAL, 32'd3, '0, 1'b1));
   endtask

   // Fill the stack, then push once more
   task automatic test_stack_overflow();
      int i;
      for (i = 0; i <= STACK_ENTRIES; i++)
         send_token(make_token(i[0] ? KIND_VARIABLE : KIND_LITERAL,
                               i[1] ? '1 : '0, i[1] ? '0 : '1, i == STACK_ENTRIES));
   endtask

   // Stall the result side while requests keep coming, then pause until drained
   task automatic test_backpressure();
      stall_request = 1'b1;
      repeat (6) begin
         build_expression($urandom_range(1, 4), 60);
         send_expression();
      end
      wait_for_results();
   endtask

   // Run both sides without any gaps
   task automatic test_back_to_back();
      int unsigned goal;
      goal = tokens_evaluated + BURST_TOKENS;
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      while (tokens_evaluated < goal) begin
         build_expression($urandom_range(1, 12), 55);
         send_expression();
      end
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // Mostly well-formed expressions, some deep, some broken, some pure noise
   task automatic test_random_mix();
      int unsigned goal;
      int          at;
      int          roll;
      goal = tokens_evaluated + MIX_TOKENS;
      while (tokens_evaluated < goal) begin
         roll = $urandom_range(99);
         if (roll < 60) begin
            build_expression($urandom_range(1, 12), 55);
            send_expression();
         end else if (roll < 75) begin
            build_expression($urandom_range(16, 40), 85);
            send_expression();
         end else if (roll < 88) begin
            build_expression($urandom_range(2, 10), 60);
            at = $urandom_range(expr_tokens.size() - 1);
            case ($urandom_range(2))
               0: expr_tokens[at].kind = KIND_W'($urandom_range(KIND_LAST_INVALID));
               1: begin
                  // end the expression early
                  expr_tokens = expr_tokens[0:at];
                  expr_tokens[at].last_token = 1'b1;
               end
               default: expr_tokens.push_front(
                           make_token(KIND_W'($urandom_range(KIND_COND, KIND_NOT)),
                                      '0, '0, 1'b0));
            endcase
            send_expression();
         end else begin
            repeat ($urandom_range(1, 6))
               send_token(random_token());
         end
      end
   endtask

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.kind        = '0;
      req_chan.literal     = '0;
      req_chan.count_value = '0;
      req_chan.last_token  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_operand_extremes();
      test_error_cases();
      test_stack_overflow();
      test_backpressure();
      test_back_to_back();
      test_random_mix();

      // Let the last divide finish and catch any stray result
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/psev_pkg.sv
rtl/core/psev_ifs.sv
rtl/core/psev_iter.sv
rtl/core/psev_dp.sv
rtl/core/psev_ctrl.sv
rtl/core/postfix_stack_evaluator_unit.sv
test/testbench.sv
